// File: src/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define NPCI_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// condition must never be seen outside reset
`define NPCI_NEVER(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

`endif

// File: src/npci_pkg.sv
// shared constants, types and palette table of the nearest palette color finder
package npci_pkg;

    localparam int PALETTE_SIZE = 256;
    localparam int PAL_AW       = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int ROM_DEPTH    = 256;
    localparam int CH_W         = 8;
    localparam int RGB_W        = 3 * CH_W;
    localparam int SQ_W         = 2 * CH_W;
    localparam int DIST_W       = SQ_W + 2;
    localparam int INDEX_W      = 8;

    localparam logic [PAL_AW-1:0] LAST_ENTRY = PAL_AW'(PALETTE_SIZE - 1);

    typedef enum logic [1:0] {
        ST_FILL,
        ST_IDLE,
        ST_BUSY,
        ST_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
    } ram_rd_t;

    typedef struct packed {
        logic              done;
        logic [PAL_AW-1:0] index;
    } search_status_t;

    typedef logic [ROM_DEPTH-1:0][RGB_W-1:0] palette_rom_t;

    function automatic logic [RGB_W-1:0] sys_color(input int k);
        logic [RGB_W-1:0] c;
        case (k)
            0:       c = {8'd0,   8'd0,   8'd0};
            1:       c = {8'd128, 8'd0,   8'd0};
            2:       c = {8'd0,   8'd128, 8'd0};
            3:       c = {8'd128, 8'd128, 8'd0};
            4:       c = {8'd0,   8'd0,   8'd128};
            5:       c = {8'd128, 8'd0,   8'd128};
            6:       c = {8'd0,   8'd128, 8'd128};
            7:       c = {8'd192, 8'd192, 8'd192};
            8:       c = {8'd128, 8'd128, 8'd128};
            9:       c = {8'd255, 8'd0,   8'd0};
            10:      c = {8'd0,   8'd255, 8'd0};
            11:      c = {8'd255, 8'd255, 8'd0};
            12:      c = {8'd0,   8'd0,   8'd255};
            13:      c = {8'd255, 8'd0,   8'd255};
            14:      c = {8'd0,   8'd255, 8'd255};
            15:      c = {8'd255, 8'd255, 8'd255};
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [CH_W-1:0] cube_level(input int k);
        logic [CH_W-1:0] v;
        case (k)
            0:       v = 8'd0;
            1:       v = 8'd95;
            2:       v = 8'd135;
            3:       v = 8'd175;
            4:       v = 8'd215;
            5:       v = 8'd255;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // evaluated at elaboration only
    function automatic palette_rom_t build_xterm_rom();
        palette_rom_t rom;
        int           c;
        int           g;
        rom = '0;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            if (i < 16) begin
                rom[i] = sys_color(i);
            end else if (i < 232) begin
                c = i - 16;
                rom[i] = {cube_level((c / 36) % 6), cube_level((c / 6) % 6),
                          cube_level(c % 6)};
            end else begin
                g = 8 + 10 * (i - 232);
                rom[i] = {CH_W'(g), CH_W'(g), CH_W'(g)};
            end
        end
        return rom;
    endfunction

    localparam palette_rom_t XTERM_ROM = build_xterm_rom();

endpackage

// File: src/npci_ram.sv
// generic single-port-write, registered-read ram
module npci_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/npci_scale.sv
// alpha premultiply of the three color channels, two pipeline stages
`include "assert_macros.svh"
module npci_scale
    import npci_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [2:0][CH_W-1:0]      pixel,
    input  logic [CH_W-1:0]           alpha,
    output logic [2:0][CH_W-1:0]      scaled,
    output logic                      done
);

    logic                  prod_valid_reg;
    logic                  done_reg;
    logic [2:0][SQ_W-1:0]  prod_reg;
    logic [2:0][SQ_W-1:0]  prod_next;
    logic [2:0][CH_W-1:0]  scaled_reg;
    logic [2:0][CH_W-1:0]  scaled_next;
    logic [2:0][SQ_W-1:0]  div_sum;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod_next[ch] = SQ_W'(pixel[ch]) * SQ_W'(alpha);
            // exact floor(p / 255) for any 16-bit product of two bytes
            div_sum[ch] = prod_reg[ch] + SQ_W'(prod_reg[ch][SQ_W-1:CH_W]) + SQ_W'(1);
            scaled_next[ch] = div_sum[ch][SQ_W-1:CH_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end else begin
            prod_valid_reg <= start;
            done_reg       <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= prod_next;
        end
        if (prod_valid_reg) begin
            scaled_reg <= scaled_next;
        end
    end

    assign scaled = scaled_reg;
    assign done   = done_reg;

    `NPCI_ASSERT(a_scale_one_start, aclk, aresetn, start |=> !start,
                 "scale started on two cycles in a row")

endmodule

// File: src/npci_search.sv
// palette scan: one entry read per cycle, squared distance, running minimum
`include "assert_macros.svh"
module npci_search
    import npci_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [2:0][CH_W-1:0]  color,
    input  logic [RGB_W-1:0]      rd_data,
    output ram_rd_t               rd,
    output search_status_t        status
);

    logic                  scan_active_reg;
    logic [PAL_AW-1:0]     scan_addr_reg;
    logic                  s1_valid_reg;
    logic                  s1_last_reg;
    logic [PAL_AW-1:0]     s1_idx_reg;
    logic                  s2_valid_reg;
    logic                  s2_last_reg;
    logic [PAL_AW-1:0]     s2_idx_reg;
    logic [2:0][SQ_W-1:0]  s2_sq_reg;
    logic [2:0][SQ_W-1:0]  sq_next;
    logic [2:0][CH_W-1:0]  entry;
    logic [2:0][CH_W-1:0]  diff;
    logic [DIST_W-1:0]     cand_dist;
    logic [DIST_W-1:0]     best_dist_reg;
    logic [PAL_AW-1:0]     best_idx_reg;
    logic                  done_reg;
    logic                  take;

    assign rd.en   = scan_active_reg;
    assign rd.addr = scan_addr_reg;

    // palette word is rrggbb, channel lane 0 is red
    assign entry[0] = rd_data[3*CH_W-1:2*CH_W];
    assign entry[1] = rd_data[2*CH_W-1:CH_W];
    assign entry[2] = rd_data[CH_W-1:0];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            diff[ch] = (color[ch] >= entry[ch]) ? (color[ch] - entry[ch])
                                                : (entry[ch] - color[ch]);
            sq_next[ch] = SQ_W'(diff[ch]) * SQ_W'(diff[ch]);
        end
        cand_dist = DIST_W'(s2_sq_reg[0]) + DIST_W'(s2_sq_reg[1]) + DIST_W'(s2_sq_reg[2]);
        // entry 0 seeds the minimum, later entries must be strictly closer
        take = s2_valid_reg && ((s2_idx_reg == '0) || (cand_dist < best_dist_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_active_reg <= 1'b0;
            scan_addr_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            done_reg        <= 1'b0;
        end else begin
            if (start) begin
                scan_active_reg <= 1'b1;
                scan_addr_reg   <= '0;
            end else if (scan_active_reg) begin
                scan_addr_reg <= scan_addr_reg + PAL_AW'(1);
                if (scan_addr_reg == LAST_ENTRY) begin
                    scan_active_reg <= 1'b0;
                end
            end
            s1_valid_reg <= scan_active_reg;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg && s2_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_idx_reg  <= scan_addr_reg;
        s1_last_reg <= (scan_addr_reg == LAST_ENTRY);
        s2_idx_reg  <= s1_idx_reg;
        s2_last_reg <= s1_last_reg;
        if (s1_valid_reg) begin
            s2_sq_reg <= sq_next;
        end
        if (take) begin
            best_dist_reg <= cand_dist;
            best_idx_reg  <= s2_idx_reg;
        end
    end

    assign status.done  = done_reg;
    assign status.index = best_idx_reg;

    `NPCI_NEVER(a_start_while_scanning, aclk, aresetn,
                start && (scan_active_reg || s1_valid_reg || s2_valid_reg),
                "new search started while a scan is in flight")
    `NPCI_ASSERT(a_done_single, aclk, aresetn, done_reg |=> !done_reg,
                 "search done raised on consecutive cycles")
    `NPCI_ASSERT(a_seed_first, aclk, aresetn,
                 (s1_valid_reg && !s2_valid_reg) |-> (s1_idx_reg == '0),
                 "scan did not begin at entry 0")

endmodule

// File: src/nearest_palette_color_index.sv
// pixels are taken one at a time: s_tready rises again only after the previous index has
//   been loaded into the output register; the scan is paced by the palette memory
//   read port, which delivers one entry per cycle to the distance pipeline
// reset: aresetn low clears control; then a fill pass writes the xterm colors into all
//   PALETTE_SIZE palette entries, s_tready stays low until it ends
// a finished index waits in the output register while the next pixel is taken
`include "assert_macros.svh"
module nearest_palette_color_index
    import npci_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // color_index [7:0]
);

    ctrl_state_t           state_reg;
    ctrl_state_t           state_next;
    logic [PAL_AW-1:0]     fill_addr_reg;
    logic [PAL_AW-1:0]     fill_addr_next;
    logic                  fill_we;
    logic                  scale_start;
    logic                  out_free;
    logic                  out_load;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [INDEX_W-1:0]    color_index_reg;
    logic [2:0][CH_W-1:0]  pixel;
    logic [2:0][CH_W-1:0]  scaled;
    logic                  scale_done;
    logic [RGB_W-1:0]      rd_data;
    ram_rd_t               rd;
    search_status_t        status;

    assign pixel[0] = s_tdata[7:0];
    assign pixel[1] = s_tdata[15:8];
    assign pixel[2] = s_tdata[23:16];

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        fill_addr_next = fill_addr_reg;
        fill_we        = 1'b0;
        s_tready       = 1'b0;
        scale_start    = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_FILL: begin
                fill_we        = 1'b1;
                fill_addr_next = fill_addr_reg + PAL_AW'(1);
                if (fill_addr_reg == LAST_ENTRY) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    scale_start = 1'b1;
                    state_next  = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (status.done) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                // best index stays in the search unit until the next start
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            fill_addr_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_addr_reg <= fill_addr_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            color_index_reg <= INDEX_W'(status.index);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = color_index_reg;

    npci_ram #(
        .WIDTH(RGB_W),
        .DEPTH(PALETTE_SIZE)
    ) u_palette (
        .aclk  (aclk),
        .we    (fill_we),
        .waddr (fill_addr_reg),
        .wdata (XTERM_ROM[INDEX_W'(fill_addr_reg)]),
        .re    (rd.en),
        .raddr (rd.addr),
        .rdata (rd_data)
    );

    npci_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scale_start),
        .pixel   (pixel),
        .alpha   (s_tdata[31:24]),
        .scaled  (scaled),
        .done    (scale_done)
    );

    npci_search u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scale_done),
        .color   (scaled),
        .rd_data (rd_data),
        .rd      (rd),
        .status  (status)
    );

    `NPCI_ASSERT(a_done_in_busy, aclk, aresetn, status.done |-> (state_reg == ST_BUSY),
                 "search finished outside of a busy pixel")
    `NPCI_NEVER(a_scan_during_fill, aclk, aresetn, rd.en && (state_reg == ST_FILL),
                "palette read while the fill pass is running")

endmodule

// File: test/nearest_palette_color_index_test.sv
// testbench for the nearest palette color finder: stream stimulus, scoreboard and checks
`timescale 1ns / 100ps

module nearest_palette_color_index_test;
    import npci_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 930;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 1500;
    localparam int CYCLE_LIMIT  = 1200000;

    // expected color indexes, oldest first, with a private copy of the xterm palette
    class color_scoreboard;
        logic [23:0] pal [256];
        logic [7:0]  expected_index [$];
        int          errors;
        int          accepted;

        function new();
            logic [23:0] sys [16];
            logic [7:0]  lvl [6];
            logic [7:0]  v;
            sys = '{24'h000000, 24'h800000, 24'h008000, 24'h808000,
                    24'h000080, 24'h800080, 24'h008080, 24'hc0c0c0,
                    24'h808080, 24'hff0000, 24'h00ff00, 24'hffff00,
                    24'h0000ff, 24'hff00ff, 24'h00ffff, 24'hffffff};
            lvl = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};
            for (int i = 0; i < 16; i++)
                pal[i] = sys[i];
            for (int i = 0; i < 216; i++)
                pal[16 + i] = {lvl[(i / 36) % 6], lvl[(i / 6) % 6], lvl[i % 6]};
            for (int i = 0; i < 24; i++) begin
                v = 8'(8 + 10 * i);
                pal[232 + i] = {v, v, v};
            end
            errors   = 0;
            accepted = 0;
        endfunction

        function int sq_distance(int r, int g, int b, logic [23:0] entry);
            int dr;
            int dg;
            int db;
            dr = r - int'(entry[23:16]);
            dg = g - int'(entry[15:8]);
            db = b - int'(entry[7:0]);
            return dr * dr + dg * dg + db * db;
        endfunction

        function logic [7:0] nearest_index(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [7:0] a);
            int pr;
            int pg;
            int pb;
            int span;
            int best;
            int best_d;
            int d;
            pr = int'(r) * int'(a) / 255;
            pg = int'(g) * int'(a) / 255;
            pb = int'(b) * int'(a) / 255;
            span = (PALETTE_SIZE > 256) ? 256 : PALETTE_SIZE;
            best = 0;
            best_d = sq_distance(pr, pg, pb, pal[0]);
            // strictly closer only, so the lowest index keeps a tie
            for (int i = 1; i < span; i++) begin
                d = sq_distance(pr, pg, pb, pal[i & 8'hff]);
                if (d < best_d) begin
                    best_d = d;
                    best = i;
                end
            end
            return 8'(best);
        endfunction

        function void note(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
            expected_index.push_back(nearest_index(r, g, b, a));
            accepted++;
        endfunction

        function int pending();
            return expected_index.size();
        endfunction

        task flag_mismatch(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check(logic [7:0] got);
            logic [7:0] want;
            if (expected_index.size() == 0) begin
                flag_mismatch($sformatf("unexpected word, color_index %0d", got));
            end else begin
                want = expected_index.pop_front();
                if (got !== want)
                    flag_mismatch($sformatf("color_index %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // color_index [7:0]

    logic            quiet   = 1'b0;
    logic            rx_hold = 1'b0;
    int              cycles  = 0;
    color_scoreboard sb;

    nearest_palette_color_index dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("nearest_palette_color_index_test NOT OK");
            $finish;
        end
    end

    // receiver side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(rx_hold || (!quiet && $urandom_range(0, 99) < 6));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check(m_tdata);
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (aresetn === 1'b1);
        @(posedge aclk);
        while (sb.accepted < 120)
            @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    function automatic int clamp_channel(int v);
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 6) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {a, b, g, r};
        do @(posedge aclk); while (!s_tready);
        sb.note(r, g, b, a);
    endtask

    task automatic wait_results_done();
        while (sb.pending() != 0) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_random_pixel();
        logic [23:0] entry;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        int          mode;
        mode = $urandom_range(0, 9);
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        a = 8'($urandom);
        if (mode < 3) begin
            // opaque pixel close to a palette entry, probing the decision boundaries
            entry = sb.pal[$urandom_range(0, 255)];
            r = 8'(clamp_channel(int'(entry[23:16]) + $urandom_range(0, 12) - 6));
            g = 8'(clamp_channel(int'(entry[15:8]) + $urandom_range(0, 12) - 6));
            b = 8'(clamp_channel(int'(entry[7:0]) + $urandom_range(0, 12) - 6));
            a = 8'hff;
        end else if (mode == 3) begin
            a = 8'hff;
        end else if (mode == 4) begin
            a = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom_range(0, 3));
        end
        send_pixel(r, g, b, a);
    endtask

    initial begin
        logic [23:0] dup_colors [8];
        sb = new();
        // duplicates of system colors inside the cube
        dup_colors = '{24'h000000, 24'hffffff, 24'h0000ff, 24'h00ff00,
                       24'h00ffff, 24'hff0000, 24'hff00ff, 24'hffff00};
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        send_pixel(8'h00, 8'h00, 8'h00, 8'hff);
        send_pixel(8'hff, 8'hff, 8'hff, 8'hff);
        send_pixel(8'hff, 8'hff, 8'hff, 8'h00);
        send_pixel(8'h5a, 8'hc3, 8'h3c, 8'h00);
        foreach (dup_colors[k])
            send_pixel(dup_colors[k][23:16], dup_colors[k][15:8], dup_colors[k][7:0], 8'hff);
        // ties between neighbor grays and between black and the darkest gray
        send_pixel(8'd13, 8'd13, 8'd13, 8'hff);
        send_pixel(8'd4, 8'd4, 8'd4, 8'hff);
        // truncation of the premultiply
        send_pixel(8'd1, 8'd1, 8'd1, 8'd254);
        send_pixel(8'hff, 8'hfe, 8'h01, 8'd254);
        send_pixel(8'd192, 8'd192, 8'd192, 8'hff);
        send_pixel(8'd238, 8'd238, 8'd238, 8'hff);
        send_pixel(8'hff, 8'h00, 8'hff, 8'd128);
        send_pixel(8'h00, 8'hff, 8'h00, 8'd1);
        send_pixel(8'haa, 8'h55, 8'haa, 8'h55);
        send_pixel(8'h55, 8'haa, 8'h55, 8'haa);
        wait_results_done();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300)
                quiet <= 1'b1;
            if (n == 450)
                quiet <= 1'b0;
            if (n == 600)
                wait_results_done();
            send_random_pixel();
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("nearest_palette_color_index_test OK");
        end else begin
            $display("nearest_palette_color_index_test NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/npci_pkg.sv
src/npci_ram.sv
src/npci_scale.sv
src/npci_search.sv
src/nearest_palette_color_index.sv
test/nearest_palette_color_index_test.sv
